/* design/ncs_pkg.sv */
// shared types and constants of the next k-combination stepper
`default_nettype none
package ncs_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int ELEM_WIDTH   = 8;
   localparam int ADDR_W       = 4;
   localparam int CNT_W        = 5;

   typedef enum logic [0:0] {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_COMBO_SIZE    = 1'b0,
      CSR_ELEMENT_COUNT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      op_type                  opcode;
      logic [ADDR_W-1:0]       position;
      logic [ELEM_WIDTH-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [ELEM_WIDTH-1:0]   element;
      logic [ADDR_W-1:0]       index;
      logic                    is_last;
      logic                    has_next;
   } rsp_type;

   typedef struct packed {
      logic                    we;
      logic [ADDR_W-1:0]       waddr;
      logic [ELEM_WIDTH-1:0]   wdata;
      logic                    re;
      logic [ADDR_W-1:0]       raddr;
   } mem_req_type;

endpackage
`default_nettype wire

/* design/next_k_combination_stepper_top.sv */
// top level of the next k-combination stepper: csr, sequencer and two stores
// load: the write goes straight to the main store and a new request is taken each cycle while idle
// advance: the last response follows the scan, swap, two copy passes through scratch and
// emission (no swap on a wrap; degenerate sizes go straight to emission), plus stalls
// one request at a time; the last response may wait in its register while the next is taken
// reset: synchronous; combo_size 1, element_count 16, store contents kept (undefined)
`default_nettype none
module next_k_combination_stepper_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  ncs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output ncs_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_we,
   input  wire                                 csr_index,
   input  wire  [ncs_pkg::CNT_W-1:0]           csr_wdata
);

   // configuration registers
   logic [ncs_pkg::CNT_W-1:0] combo_size_ff,  combo_size_in;
   logic [ncs_pkg::CNT_W-1:0] elem_count_ff,  elem_count_in;
   // element count clamped to the store depth
   logic [ncs_pkg::CNT_W-1:0] elem_count_eff;

   // memory traffic between sequencer and the two stores
   ncs_pkg::mem_req_type           main_req;
   ncs_pkg::mem_req_type           scr_req;
   logic [ncs_pkg::ELEM_WIDTH-1:0] main_rd;
   logic [ncs_pkg::ELEM_WIDTH-1:0] scr_rd;

   always_comb begin
      combo_size_in = combo_size_ff;
      elem_count_in = elem_count_ff;
      if (csr_we) begin
         unique case (ncs_pkg::csr_idx_type'(csr_index))
            ncs_pkg::CSR_COMBO_SIZE:    combo_size_in = csr_wdata;
            ncs_pkg::CSR_ELEMENT_COUNT: elem_count_in = csr_wdata;
            default:                    combo_size_in = combo_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         combo_size_ff <= ncs_pkg::CNT_W'(1);
         elem_count_ff <= ncs_pkg::CNT_W'(ncs_pkg::MAX_ELEMENTS);
      end else begin
         combo_size_ff <= combo_size_in;
         elem_count_ff <= elem_count_in;
      end
   end

   // counts beyond the store depth behave as the full depth
   assign elem_count_eff = (elem_count_ff > ncs_pkg::CNT_W'(ncs_pkg::MAX_ELEMENTS)) ?
                           ncs_pkg::CNT_W'(ncs_pkg::MAX_ELEMENTS) : elem_count_ff;

   // sequencer: scan for the pivot, swap, rotate via scratch, stream out entries
   ncs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .combo_size (combo_size_ff),
      .elem_count (elem_count_eff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .main_req   (main_req),
      .main_rd    (main_rd),
      .scr_req    (scr_req),
      .scr_rd     (scr_rd)
   );

   // main sequence store, holds the combination and remainder
   ncs_ram u_main_ram (
      .clock   (clock),
      .mem_req (main_req),
      .rd_data (main_rd)
   );

   // scratch store, intermediate result between the two rotation passes
   ncs_ram u_scr_ram (
      .clock   (clock),
      .mem_req (scr_req),
      .rd_data (scr_rd)
   );

endmodule
`default_nettype wire

/* design/ncs_ram.sv */
// one-write one-read synchronous store with registered read data
`default_nettype none
module ncs_ram (
   input  wire                                 clock,
   input  ncs_pkg::mem_req_type                mem_req,
   output logic [ncs_pkg::ELEM_WIDTH-1:0]      rd_data
);

   logic [ncs_pkg::ELEM_WIDTH-1:0] store_ff [ncs_pkg::MAX_ELEMENTS];
   logic [ncs_pkg::ELEM_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
      // read data holds while no read is issued
      if (mem_req.re) begin
         rd_data_ff <= store_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/ncs_seq.sv */
// sequencer: scan, swap, two rotation passes through scratch, emission
`default_nettype none
module ncs_seq (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [ncs_pkg::CNT_W-1:0]           combo_size,
   input  wire  [ncs_pkg::CNT_W-1:0]           elem_count,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  ncs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output ncs_pkg::rsp_type                    rsp_data,
   output ncs_pkg::mem_req_type                main_req,
   input  wire  [ncs_pkg::ELEM_WIDTH-1:0]      main_rd,
   output ncs_pkg::mem_req_type                scr_req,
   input  wire  [ncs_pkg::ELEM_WIDTH-1:0]      scr_rd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAST_WT,
      ST_SCAN_I,
      ST_SCAN_J,
      ST_SWAP_I,
      ST_SWAP_J,
      ST_COPY,
      ST_COPY_DR,
      ST_BACK,
      ST_BACK_DR,
      ST_EMIT_RD,
      ST_EMIT_WT
   } state_type;

   localparam int AW = ncs_pkg::ADDR_W;
   localparam int CW = ncs_pkg::CNT_W;
   localparam int EW = ncs_pkg::ELEM_WIDTH;

   state_type         state_ff,    state_in;
   logic [AW-1:0]     i_ff,        i_in;
   logic [AW-1:0]     j_ff,        j_in;
   logic [AW-1:0]     p_ff,        p_in;
   logic [AW-1:0]     src_ff,      src_in;
   logic [AW-1:0]     a_ff,        a_in;
   logic [AW-1:0]     bl_ff,       bl_in;
   logic [AW-1:0]     bm_ff,       bm_in;
   logic [AW-1:0]     e_ff,        e_in;
   logic [AW-1:0]     pipe_addr_ff, pipe_addr_in;
   logic              cp_vld_ff,   cp_vld_in;
   logic              bk_vld_ff,   bk_vld_in;
   logic              more_ff,     more_in;
   logic              rsp_vld_ff,  rsp_vld_in;
   logic [EW-1:0]     last_ff,     last_in;
   logic [EW-1:0]     vi_ff,       vi_in;
   logic [EW-1:0]     vj_ff,       vj_in;
   ncs_pkg::rsp_type  rsp_ff,      rsp_in;

   logic [CW-1:0]     n_m1;
   logic [CW-1:0]     mid_a;
   logic [CW-1:0]     m_b;
   logic [CW-1:0]     src_nx;
   logic              accept;
   logic              degenerate;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign n_m1       = elem_count - CW'(1);
   assign degenerate = (elem_count < CW'(2)) || (combo_size == '0) ||
                       (combo_size >= elem_count);
   assign mid_a      = {1'b0, j_ff} + CW'(1);
   assign m_b        = combo_size + elem_count - {1'b0, j_ff} - CW'(1);
   assign src_nx     = {1'b0, src_ff} + CW'(1);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      src_in       = src_ff;
      a_in         = a_ff;
      bl_in        = bl_ff;
      bm_in        = bm_ff;
      e_in         = e_ff;
      pipe_addr_in = pipe_addr_ff;
      cp_vld_in    = 1'b0;
      bk_vld_in    = 1'b0;
      more_in      = more_ff;
      last_in      = last_ff;
      vi_in        = vi_ff;
      vj_in        = vj_ff;
      rsp_in       = rsp_ff;
      rsp_vld_in   = rsp_vld_ff && rsp_stall;
      main_req     = '0;
      scr_req      = '0;

      // write half of the copy passes, in the cycle after the read
      if (cp_vld_ff) begin
         scr_req.we    = 1'b1;
         scr_req.waddr = pipe_addr_ff;
         scr_req.wdata = main_rd;
      end
      if (bk_vld_ff) begin
         main_req.we    = 1'b1;
         main_req.waddr = pipe_addr_ff;
         main_req.wdata = scr_rd;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == ncs_pkg::OP_LOAD) begin
                  main_req.we    = 1'b1;
                  main_req.waddr = req_data.position;
                  main_req.wdata = req_data.value;
               end else begin
                  e_in = '0;
                  if (elem_count == '0) begin
                     state_in = ST_IDLE;
                  end else if (degenerate) begin
                     more_in  = 1'b0;
                     state_in = ST_EMIT_RD;
                  end else begin
                     main_req.re    = 1'b1;
                     main_req.raddr = n_m1[AW-1:0];
                     i_in           = AW'(combo_size - CW'(1));
                     state_in       = ST_LAST_WT;
                  end
               end
            end
         end
         ST_LAST_WT: begin
            last_in        = main_rd;
            main_req.re    = 1'b1;
            main_req.raddr = i_ff;
            state_in       = ST_SCAN_I;
         end
         ST_SCAN_I: begin
            if (main_rd < last_ff) begin
               vi_in          = main_rd;
               j_in           = combo_size[AW-1:0];
               main_req.re    = 1'b1;
               main_req.raddr = combo_size[AW-1:0];
               state_in       = ST_SCAN_J;
            end else if (i_ff == '0) begin
               // no successor: rotate whole run left by combo_size
               more_in  = 1'b0;
               a_in     = '0;
               p_in     = '0;
               src_in   = '0;
               bl_in    = '0;
               bm_in    = combo_size[AW-1:0];
               state_in = ST_COPY;
            end else begin
               i_in           = i_ff - AW'(1);
               main_req.re    = 1'b1;
               main_req.raddr = i_ff - AW'(1);
            end
         end
         ST_SCAN_J: begin
            if ((vi_ff < main_rd) || ({1'b0, j_ff} == n_m1)) begin
               vj_in    = main_rd;
               state_in = ST_SWAP_I;
            end else begin
               j_in           = j_ff + AW'(1);
               main_req.re    = 1'b1;
               main_req.raddr = j_ff + AW'(1);
            end
         end
         ST_SWAP_I: begin
            main_req.we    = 1'b1;
            main_req.waddr = i_ff;
            main_req.wdata = vj_ff;
            state_in       = ST_SWAP_J;
         end
         ST_SWAP_J: begin
            main_req.we    = 1'b1;
            main_req.waddr = j_ff;
            main_req.wdata = vi_ff;
            more_in        = 1'b1;
            a_in           = i_ff + AW'(1);
            p_in           = i_ff + AW'(1);
            src_in         = (mid_a == elem_count) ? (i_ff + AW'(1)) : mid_a[AW-1:0];
            bl_in          = combo_size[AW-1:0];
            bm_in          = m_b[AW-1:0];
            state_in       = ST_COPY;
         end
         ST_COPY: begin
            main_req.re    = 1'b1;
            main_req.raddr = src_ff;
            cp_vld_in      = 1'b1;
            pipe_addr_in   = p_ff;
            src_in         = (src_nx == elem_count) ? a_ff : src_nx[AW-1:0];
            if ({1'b0, p_ff} == n_m1) begin
               state_in = ST_COPY_DR;
            end else begin
               p_in = p_ff + AW'(1);
            end
         end
         ST_COPY_DR: begin
            p_in     = a_ff;
            src_in   = bm_ff;
            state_in = ST_BACK;
         end
         ST_BACK: begin
            scr_req.re   = 1'b1;
            bk_vld_in    = 1'b1;
            pipe_addr_in = p_ff;
            if (p_ff < bl_ff) begin
               scr_req.raddr = p_ff;
            end else begin
               scr_req.raddr = src_ff;
               src_in        = (src_nx == elem_count) ? bl_ff : src_nx[AW-1:0];
            end
            if ({1'b0, p_ff} == n_m1) begin
               state_in = ST_BACK_DR;
            end else begin
               p_in = p_ff + AW'(1);
            end
         end
         ST_BACK_DR: begin
            e_in     = '0;
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            main_req.re    = 1'b1;
            main_req.raddr = e_ff;
            state_in       = ST_EMIT_WT;
         end
         ST_EMIT_WT: begin
            if (!rsp_vld_ff || !rsp_stall) begin
               rsp_vld_in       = 1'b1;
               rsp_in.element   = main_rd;
               rsp_in.index     = e_ff;
               rsp_in.is_last   = ({1'b0, e_ff} == n_m1);
               rsp_in.has_next  = more_ff;
               if ({1'b0, e_ff} == n_m1) begin
                  state_in = ST_IDLE;
               end else begin
                  e_in           = e_ff + AW'(1);
                  main_req.re    = 1'b1;
                  main_req.raddr = e_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cp_vld_ff  <= 1'b0;
         bk_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         more_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cp_vld_ff  <= cp_vld_in;
         bk_vld_ff  <= bk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         more_ff    <= more_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      p_ff         <= p_in;
      src_ff       <= src_in;
      a_ff         <= a_in;
      bl_ff        <= bl_in;
      bm_ff        <= bm_in;
      e_ff         <= e_in;
      pipe_addr_ff <= pipe_addr_in;
      last_ff      <= last_in;
      vi_ff        <= vi_in;
      vj_ff        <= vj_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
